[hdl/mf3_pkg.sv]
`timescale 1ns / 1ps

package mf3_pkg;

    // Window geometry: three rows of three taps.
    localparam int WIN_TAPS = 9;

    // Default build parameters.
    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_SAMPLE_BITS = 16;

    // Configuration registers.
    localparam int CFG_WIDTH_BITS  = 11;
    localparam int CFG_HEIGHT_BITS = 16;
    localparam int CFG_DATA_BITS   = 16;
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;
    localparam int RESET_WIDTH  = 45;
    localparam int RESET_HEIGHT = 44;

    // The row counter runs two rows past the last row of the frame while draining.
    localparam int ROW_BITS = CFG_HEIGHT_BITS + 1;

    // Result queue depth; it must cover the filter pipeline plus some slack.
    localparam int FIFO_DEPTH = 8;

    // Input action codes.
    localparam logic ACT_PUSH  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    // Which window edges fall outside the image for the output pixel.
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } border_t;

    // Control that travels alongside a window through the median pipeline.
    typedef struct packed {
        logic valid;
        logic eof;
    } tag_t;

endpackage

[hdl/median_filter_3x3_zero_pad.sv]
`timescale 1ns / 1ps
// 3x3 median filter with zero padding over a raster pixel stream.
// A request that completes a result passes the line store read, the window shift, the
// three median stages and the queue before that result can be taken.
// Throughput: one request per clock; the input stalls only while every result queue slot
// is reserved by a result waiting in the queue or still in the pipeline.
// Reset (aresetn low, synchronous) restores width 45, height 44, clears position and queue.
module median_filter_3x3_zero_pad #(
    parameter int MAX_WIDTH   = mf3_pkg::DEF_MAX_WIDTH,
    parameter int SAMPLE_BITS = mf3_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // Pixel input channel.
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0]  s_tdata,  // [SAMPLE_BITS-1:0] sample
    input  logic                                    s_tuser,  // [0] action
    // Result channel.
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0]  m_tdata,  // [SAMPLE_BITS-1:0] median_value
    output logic                                    m_tlast,  // end_of_frame
    // Configuration write channel.
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic                                    cfg_index,
    input  logic [mf3_pkg::CFG_DATA_BITS-1:0]       cfg_data
);

    localparam int TD_W     = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int ADDR_W   = $clog2(MAX_WIDTH);
    localparam int CNT_W    = $clog2(MAX_WIDTH + 1);
    localparam int COL_W    = ADDR_W + 1;
    localparam int ROW_W    = mf3_pkg::ROW_BITS;
    localparam int CREDIT_W = $clog2(mf3_pkg::FIFO_DEPTH + 1);

    // The configured width is clamped to 2..MAX_WIDTH when it is written, so the
    // datapath only ever sees the effective value.
    function automatic logic [CNT_W-1:0] clamp_width(
        input logic [mf3_pkg::CFG_WIDTH_BITS-1:0] v
    );
        if (v < mf3_pkg::CFG_WIDTH_BITS'(2)) begin
            return CNT_W'(2);
        end else if (32'(v) > 32'(MAX_WIDTH)) begin
            return CNT_W'(MAX_WIDTH);
        end else begin
            return CNT_W'(v);
        end
    endfunction

    function automatic logic [mf3_pkg::CFG_HEIGHT_BITS-1:0] clamp_height(
        input logic [mf3_pkg::CFG_HEIGHT_BITS-1:0] v
    );
        return (v < mf3_pkg::CFG_HEIGHT_BITS'(2)) ? mf3_pkg::CFG_HEIGHT_BITS'(2) : v;
    endfunction

    // Effective frame geometry.
    logic [CNT_W-1:0]                   width_reg;
    logic [mf3_pkg::CFG_HEIGHT_BITS-1:0] height_reg;

    // Raster position of the next pixel and the result queue reservation count.
    logic [ADDR_W-1:0]   col_reg;
    logic [ADDR_W-1:0]   col_next;
    logic [ROW_W-1:0]    row_reg;
    logic [ROW_W-1:0]    row_next;
    logic [CREDIT_W-1:0] credit_reg;
    logic [CREDIT_W-1:0] credit_next;

    // Decode of the request at the input.
    logic                          cfg_write;
    logic                          s_accept;
    logic                          draining;
    logic                          do_item;
    logic [ADDR_W-1:0]             col_cur;
    logic [COL_W-1:0]              col_inc;
    logic                          row_done;
    logic signed [SAMPLE_BITS-1:0] pix_val;
    logic                          emit;
    logic [ROW_W-1:0]              out_row;
    logic [ADDR_W-1:0]             out_col;
    logic [ADDR_W-1:0]             width_m1;
    logic [ROW_W-1:0]              height_m1;
    mf3_pkg::border_t              border_cur;
    logic                          eof_cur;

    // Stage one: the request waits for its line store read.
    logic                          s1_valid_reg;
    logic                          s1_emit_reg;
    logic                          s1_eof_reg;
    mf3_pkg::border_t              s1_border_reg;
    logic [ADDR_W-1:0]             s1_addr_reg;
    logic signed [SAMPLE_BITS-1:0] s1_val_reg;

    // Stage two: the shifted window and its control.
    logic signed [SAMPLE_BITS-1:0] win_reg [mf3_pkg::WIN_TAPS];
    mf3_pkg::tag_t                 s2_tag_reg;
    mf3_pkg::border_t              s2_border_reg;

    logic signed [SAMPLE_BITS-1:0] rd_upper;
    logic signed [SAMPLE_BITS-1:0] rd_middle;
    mf3_pkg::tag_t                 med_tag;
    logic signed [SAMPLE_BITS-1:0] med_value;
    logic [SAMPLE_BITS:0]          fifo_out;

    // Always taken, unchecked; user must write configuration only while the block is idle.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // The input is held off only when every result queue slot is spoken for,
    // counting the results still travelling through the filter pipeline.
    assign s_tready = (credit_reg < CREDIT_W'(mf3_pkg::FIFO_DEPTH));
    assign s_accept = s_tvalid && s_tready;

    // Once every pixel of the frame has arrived, any request drains one output
    // and feeds zeros. A flush request before that point is dropped without effect.
    assign draining = (row_reg >= ROW_W'(height_reg));
    assign do_item  = s_accept && !(s_tuser == mf3_pkg::ACT_FLUSH && !draining);

    always_comb begin
        col_cur   = (COL_W'(col_reg) >= COL_W'(width_reg)) ? '0 : col_reg;
        col_inc   = COL_W'(col_cur) + COL_W'(1);
        row_done  = (col_inc >= COL_W'(width_reg));
        pix_val   = draining ? '0 : $signed(s_tdata[SAMPLE_BITS-1:0]);
        width_m1  = ADDR_W'(width_reg - CNT_W'(1));
        height_m1 = ROW_W'(height_reg) - ROW_W'(1);

        // A pixel's result is complete once its lower right neighbor has arrived.
        emit = (row_reg >= ROW_W'(2)) || (row_reg == ROW_W'(1) && col_cur != '0);

        // Position of the output pixel that this request completes. At the
        // start of a row it is the last pixel of the row two above.
        if (col_cur != '0) begin
            out_row = row_reg - ROW_W'(1);
            out_col = col_cur - ADDR_W'(1);
        end else begin
            out_row = row_reg - ROW_W'(2);
            out_col = width_m1;
        end

        border_cur.top    = (out_row == '0);
        border_cur.bottom = (out_row == height_m1);
        border_cur.left   = (out_col == '0);
        border_cur.right  = (out_col == width_m1);
        eof_cur           = border_cur.bottom && border_cur.right;
    end

    // Position update. A configuration write or the end-of-frame output starts
    // a new frame at the top left.
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        priority if (cfg_write) begin
            col_next = '0;
            row_next = '0;
        end else if (do_item && emit && eof_cur) begin
            col_next = '0;
            row_next = '0;
        end else if (do_item && row_done) begin
            col_next = '0;
            row_next = row_reg + ROW_W'(1);
        end else if (do_item) begin
            col_next = ADDR_W'(col_inc);
        end
    end

    // A slot is reserved when a result-bearing request enters, freed when the
    // result is taken downstream.
    always_comb begin
        credit_next = credit_reg;
        if (do_item && emit && !(m_tvalid && m_tready)) begin
            credit_next = credit_reg + CREDIT_W'(1);
        end else if (!(do_item && emit) && m_tvalid && m_tready) begin
            credit_next = credit_reg - CREDIT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= clamp_width(mf3_pkg::CFG_WIDTH_BITS'(mf3_pkg::RESET_WIDTH));
            height_reg <= mf3_pkg::CFG_HEIGHT_BITS'(mf3_pkg::RESET_HEIGHT);
            col_reg    <= '0;
            row_reg    <= '0;
            credit_reg <= '0;
        end else begin
            if (cfg_write) begin
                unique case (cfg_index)
                    mf3_pkg::REG_IMAGE_WIDTH: begin
                        width_reg <= clamp_width(cfg_data[mf3_pkg::CFG_WIDTH_BITS-1:0]);
                    end
                    mf3_pkg::REG_IMAGE_HEIGHT: begin
                        height_reg <= clamp_height(cfg_data[mf3_pkg::CFG_HEIGHT_BITS-1:0]);
                    end
                    default: begin
                    end
                endcase
            end
            col_reg    <= col_next;
            row_reg    <= row_next;
            credit_reg <= credit_next;
        end
    end

    // The line stores are read on acceptance and written back in the following cycle:
    // the middle row moves up and the new pixel takes its place. Entries from an
    // earlier frame or from before reset only ever land in masked window taps,
    // so the stores need no clearing pass.
    mf3_line_mem #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_line_mem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (do_item),
        .rd_addr   (col_cur),
        .rd_upper  (rd_upper),
        .rd_middle (rd_middle),
        .wr_en     (s1_valid_reg),
        .wr_addr   (s1_addr_reg),
        .wr_upper  (rd_middle),
        .wr_middle (s1_val_reg)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_tag_reg   <= '0;
        end else begin
            s1_valid_reg     <= do_item;
            s2_tag_reg.valid <= s1_valid_reg && s1_emit_reg;
            s2_tag_reg.eof   <= s1_eof_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_item) begin
            s1_emit_reg   <= emit;
            s1_eof_reg    <= eof_cur;
            s1_border_reg <= border_cur;
            s1_addr_reg   <= col_cur;
            s1_val_reg    <= pix_val;
        end
        s2_border_reg <= s1_border_reg;
    end

    // The window slides one column left; the newest column comes from the two
    // line stores and the incoming pixel.
    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            for (int k = 0; k < 3; k++) begin
                win_reg[3*k]   <= win_reg[3*k+1];
                win_reg[3*k+1] <= win_reg[3*k+2];
            end
            win_reg[2] <= rd_upper;
            win_reg[5] <= rd_middle;
            win_reg[8] <= s1_val_reg;
        end
    end

    mf3_median #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_median (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_tag     (s2_tag_reg),
        .in_border  (s2_border_reg),
        .win        (win_reg),
        .out_tag    (med_tag),
        .out_median (med_value)
    );

    mf3_out_fifo #(
        .DATA_BITS (SAMPLE_BITS + 1),
        .DEPTH     (mf3_pkg::FIFO_DEPTH)
    ) u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (med_tag.valid),
        .push_data ({med_tag.eof, med_value}),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (fifo_out)
    );

    assign m_tdata = TD_W'(fifo_out[SAMPLE_BITS-1:0]);
    assign m_tlast = fifo_out[SAMPLE_BITS];

endmodule

[hdl/mf3_line_mem.sv]
`timescale 1ns / 1ps

// Two line stores sharing one address: the upper and the middle row.
// Read data is registered; a write to the address being read in the same
// cycle is forwarded so the reader sees the new contents.
module mf3_line_mem #(
    parameter int MAX_WIDTH   = mf3_pkg::DEF_MAX_WIDTH,
    parameter int SAMPLE_BITS = mf3_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]         rd_addr,
    output logic signed [SAMPLE_BITS-1:0]        rd_upper,
    output logic signed [SAMPLE_BITS-1:0]        rd_middle,
    input  logic                                 wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]         wr_addr,
    input  logic signed [SAMPLE_BITS-1:0]        wr_upper,
    input  logic signed [SAMPLE_BITS-1:0]        wr_middle
);

    logic signed [SAMPLE_BITS-1:0] upper_mem [MAX_WIDTH];
    logic signed [SAMPLE_BITS-1:0] middle_mem [MAX_WIDTH];

    logic signed [SAMPLE_BITS-1:0] upper_q_reg;
    logic signed [SAMPLE_BITS-1:0] middle_q_reg;
    logic signed [SAMPLE_BITS-1:0] byp_upper_reg;
    logic signed [SAMPLE_BITS-1:0] byp_middle_reg;
    logic                          bypass_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            upper_mem[wr_addr]  <= wr_upper;
            middle_mem[wr_addr] <= wr_middle;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            upper_q_reg    <= upper_mem[rd_addr];
            middle_q_reg   <= middle_mem[rd_addr];
            byp_upper_reg  <= wr_upper;
            byp_middle_reg <= wr_middle;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bypass_reg <= 1'b0;
        end else if (rd_en) begin
            bypass_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_upper  = bypass_reg ? byp_upper_reg  : upper_q_reg;
    assign rd_middle = bypass_reg ? byp_middle_reg : middle_q_reg;

endmodule

[hdl/mf3_median.sv]
`timescale 1ns / 1ps

// Three-stage median of a masked 3x3 window. Stage one zeroes the taps that
// lie outside the image and sorts each row; stage two takes the largest row
// minimum, the median of the row medians and the smallest row maximum; stage
// three takes the median of those three.
module mf3_median #(
    parameter int SAMPLE_BITS = mf3_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mf3_pkg::tag_t                 in_tag,
    input  mf3_pkg::border_t              in_border,
    input  logic signed [SAMPLE_BITS-1:0] win [mf3_pkg::WIN_TAPS],
    output mf3_pkg::tag_t                 out_tag,
    output logic signed [SAMPLE_BITS-1:0] out_median
);

    localparam int ROWS = mf3_pkg::WIN_TAPS / 3;

    function automatic logic signed [SAMPLE_BITS-1:0] min2(
        input logic signed [SAMPLE_BITS-1:0] a,
        input logic signed [SAMPLE_BITS-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] max2(
        input logic signed [SAMPLE_BITS-1:0] a,
        input logic signed [SAMPLE_BITS-1:0] b
    );
        return (a < b) ? b : a;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] med3(
        input logic signed [SAMPLE_BITS-1:0] a,
        input logic signed [SAMPLE_BITS-1:0] b,
        input logic signed [SAMPLE_BITS-1:0] c
    );
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    logic signed [SAMPLE_BITS-1:0] masked [mf3_pkg::WIN_TAPS];
    logic signed [SAMPLE_BITS-1:0] lo_reg [ROWS];
    logic signed [SAMPLE_BITS-1:0] md_reg [ROWS];
    logic signed [SAMPLE_BITS-1:0] hi_reg [ROWS];
    logic signed [SAMPLE_BITS-1:0] lo_max_reg;
    logic signed [SAMPLE_BITS-1:0] md_med_reg;
    logic signed [SAMPLE_BITS-1:0] hi_min_reg;
    logic signed [SAMPLE_BITS-1:0] median_reg;
    mf3_pkg::tag_t                 tag1_reg;
    mf3_pkg::tag_t                 tag2_reg;
    mf3_pkg::tag_t                 tag3_reg;

    always_comb begin
        for (int i = 0; i < mf3_pkg::WIN_TAPS; i++) begin
            if ((i < 3 && in_border.top) || (i >= 6 && in_border.bottom) ||
                ((i % 3) == 0 && in_border.left) || ((i % 3) == 2 && in_border.right)) begin
                masked[i] = '0;
            end else begin
                masked[i] = win[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < ROWS; k++) begin
            lo_reg[k] <= min2(min2(masked[3*k], masked[3*k+1]), masked[3*k+2]);
            md_reg[k] <= med3(masked[3*k], masked[3*k+1], masked[3*k+2]);
            hi_reg[k] <= max2(max2(masked[3*k], masked[3*k+1]), masked[3*k+2]);
        end
        lo_max_reg <= max2(max2(lo_reg[0], lo_reg[1]), lo_reg[2]);
        md_med_reg <= med3(md_reg[0], md_reg[1], md_reg[2]);
        hi_min_reg <= min2(min2(hi_reg[0], hi_reg[1]), hi_reg[2]);
        median_reg <= med3(lo_max_reg, md_med_reg, hi_min_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end else begin
            tag1_reg <= in_tag;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    assign out_tag    = tag3_reg;
    assign out_median = median_reg;

endmodule

[hdl/mf3_out_fifo.sv]
`timescale 1ns / 1ps

// Small result queue. The writer never pushes into a full queue: the caller
// reserves a slot before an item enters the filter pipeline.
module mf3_out_fifo #(
    parameter int DATA_BITS = mf3_pkg::DEF_SAMPLE_BITS + 1,
    parameter int DEPTH     = mf3_pkg::FIFO_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  logic [DATA_BITS-1:0] push_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [DATA_BITS-1:0] out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_BITS-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]     head_reg;
    logic [PTR_W-1:0]     tail_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [PTR_W-1:0]     head_next;
    logic [PTR_W-1:0]     tail_next;
    logic [CNT_W-1:0]     count_next;
    logic                 pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[head_reg];

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (pop) begin
            head_next = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);
        end
        if (push) begin
            tail_next = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[tail_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

[hdl/mf3_checker.sv]
`timescale 1ns / 1ps

// Port-level checks for the median filter.
module mf3_checker #(
    parameter int SAMPLE_BITS = mf3_pkg::DEF_SAMPLE_BITS
) (
    input logic                                   aclk,
    input logic                                   aresetn,
    input logic                                   s_tready,
    input logic                                   m_tvalid,
    input logic                                   m_tready,
    input logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] m_tdata,
    input logic                                   m_tlast
);

    // Reset empties the result queue.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending right after reset");

    // The input only stalls when every queue slot is reserved, which always leaves results waiting.
    a_stall_has_results: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn before it was taken");

    a_payload_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

endmodule

bind median_filter_3x3_zero_pad mf3_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_mf3_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

[tb/sv/tb_median_filter_3x3_zero_pad.sv]
`timescale 1ns / 1ps

module tb_median_filter_3x3_zero_pad;

    localparam int MAX_W  = mf3_pkg::DEF_MAX_WIDTH;
    localparam int SBITS  = mf3_pkg::DEF_SAMPLE_BITS;
    localparam int DATA_W = ((SBITS + 7) / 8) * 8;

    // Pushes and drain ticks that count toward the random part of the run.
    localparam int RANDOM_ITEMS  = 600;
    // Wait this long before a register write so that requests without a result
    // have left the pipe.
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_CYCLES  = 20;
    // One long stretch in which the receiver refuses results while pixels keep coming.
    localparam int HOLD_CYCLES   = 300;
    // Cycles without any request on any channel before the run is declared hung.
    localparam int STALL_LIMIT   = 5000;

    typedef struct {
        logic signed [SBITS-1:0] median_value;
        logic                    end_of_frame;
    } pixel_result_t;

    // Tracks the filter state, predicts the median for each accepted pixel request,
    // and checks the results in order.
    class median_scoreboard;
        int unsigned   width_reg;
        int unsigned   height_reg;
        int            upper_row [MAX_W];
        int            middle_row [MAX_W];
        int            window [mf3_pkg::WIN_TAPS];
        int unsigned   col;
        int unsigned   row;
        pixel_result_t expected [$];
        int            failures;
        int            taken;

        function new();
            width_reg  = mf3_pkg::RESET_WIDTH;
            height_reg = mf3_pkg::RESET_HEIGHT;
            foreach (upper_row[i]) begin
                upper_row[i]  = 0;
                middle_row[i] = 0;
            end
            foreach (window[i]) window[i] = 0;
            col      = 0;
            row      = 0;
            failures = 0;
            taken    = 0;
        endfunction

        static function int unsigned usable_width(int unsigned raw);
            int unsigned w;
            w = raw & ((1 << mf3_pkg::CFG_WIDTH_BITS) - 1);
            if (w < 2) return 2;
            if (w > MAX_W) return MAX_W;
            return w;
        endfunction

        static function int unsigned usable_height(int unsigned raw);
            int unsigned h;
            h = raw & ((1 << mf3_pkg::CFG_HEIGHT_BITS) - 1);
            return (h < 2) ? 2 : h;
        endfunction

        function void set_register(logic idx, logic [mf3_pkg::CFG_DATA_BITS-1:0] data);
            if (idx == mf3_pkg::REG_IMAGE_WIDTH)
                width_reg = data;
            else
                height_reg = data;
            col = 0;
            row = 0;
        endfunction

        function int median_of(int taps [mf3_pkg::WIN_TAPS]);
            int sorted [mf3_pkg::WIN_TAPS];
            int t;
            int j;
            int k;
            sorted = taps;
            for (k = 1; k < mf3_pkg::WIN_TAPS; k++) begin
                t = sorted[k];
                j = k;
                while (j > 0 && sorted[j-1] > t) begin
                    sorted[j] = sorted[j-1];
                    j--;
                end
                sorted[j] = t;
            end
            return sorted[mf3_pkg::WIN_TAPS / 2];
        endfunction

        function void take_pixel(logic act, logic [SBITS-1:0] raw);
            int unsigned   w;
            int unsigned   h;
            int unsigned   c;
            int unsigned   r;
            int unsigned   orow;
            int unsigned   ocol;
            int            val;
            int            top;
            int            mid;
            int            nb [mf3_pkg::WIN_TAPS];
            int            k;
            int            rr;
            int            cc;
            bit            masked;
            bit            emit;
            pixel_result_t res;
            w = usable_width(width_reg);
            h = usable_height(height_reg);
            c = col;
            r = row;
            // A flush tick before the last pixel of the frame does nothing at all.
            if (r < h && act == mf3_pkg::ACT_FLUSH) return;
            taken++;
            // While draining, every request acts as a flush and feeds a zero.
            val = (r >= h) ? 0 : int'($signed(raw));
            if (c >= w) c = 0;

            top = upper_row[c];
            mid = middle_row[c];
            upper_row[c]  = mid;
            middle_row[c] = val;
            for (k = 0; k < 3; k++) begin
                window[k*3]     = window[k*3 + 1];
                window[k*3 + 1] = window[k*3 + 2];
            end
            window[2] = top;
            window[5] = mid;
            window[8] = val;

            emit = (r >= 2) || (r == 1 && c >= 1);
            if (c + 1 >= w) begin
                col = 0;
                row = r + 1;
            end else begin
                col = c + 1;
            end
            if (!emit) return;

            // The window center lags the input by one row and one column.
            if (c >= 1) begin
                orow = r - 1;
                ocol = c - 1;
            end else begin
                orow = r - 2;
                ocol = w - 1;
            end
            for (rr = 0; rr < 3; rr++) begin
                for (cc = 0; cc < 3; cc++) begin
                    masked = (rr == 0 && orow == 0) || (rr == 2 && orow == h - 1) ||
                             (cc == 0 && ocol == 0) || (cc == 2 && ocol == w - 1);
                    nb[rr*3 + cc] = masked ? 0 : window[rr*3 + cc];
                end
            end
            res.median_value = SBITS'(median_of(nb));
            res.end_of_frame = (orow == h - 1) && (ocol == w - 1);
            if (res.end_of_frame) begin
                col = 0;
                row = 0;
            end
            expected.push_back(res);
        endfunction

        function void check_median(logic [SBITS-1:0] got_value, logic got_last);
            pixel_result_t want;
            if (expected.size() == 0) begin
                failures++;
                $display("%0t: result with none expected: median %0d last %0b",
                         $time, $signed(got_value), got_last);
                return;
            end
            want = expected.pop_front();
            if (got_value !== want.median_value) begin
                failures++;
                $display("%0t: median_value expected %0d actual %0d",
                         $time, want.median_value, $signed(got_value));
            end
            if (got_last !== want.end_of_frame) begin
                failures++;
                $display("%0t: end_of_frame expected %0b actual %0b",
                         $time, want.end_of_frame, got_last);
            end
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;
    logic              s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] m_tdata;
    logic              m_tlast;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_index;
    logic [mf3_pkg::CFG_DATA_BITS-1:0] cfg_data;

    median_scoreboard sb = new();

    // Idle percentages per phase: the sender idles more lightly first, then the
    // receiver does, and in the last phase neither side idles at all.
    int idle_phase = 0;
    int send_idle [3] = '{38, 75, 0};
    int recv_idle [3] = '{75, 38, 0};
    bit hold_armed = 1'b0;
    int stall_cycles = 0;

    median_filter_3x3_zero_pad dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Every request is observed at the clock edge where it happens. All drivers use
    // nonblocking updates, so the values read here are the ones the block sampled.
    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            if (cfg_valid && cfg_ready)
                sb.set_register(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                sb.take_pixel(s_tuser, s_tdata[SBITS-1:0]);
            if (m_tvalid && m_tready)
                sb.check_median(m_tdata[SBITS-1:0], m_tlast);
        end
    end

    // Watchdog: any request on any channel restarts the count.
    always @(posedge aclk) begin
        if (aresetn !== 1'b1 || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles = stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Result receiver. Once armed, the first waiting result starts a long refusal so
    // that the result queue fills up and the block has to stall its pixel input.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_armed && m_tvalid === 1'b1) begin
                hold_armed = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= ($urandom_range(99) >= recv_idle[idle_phase]);
        end
    end

    function automatic logic [SBITS-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return {1'b0, {(SBITS-1){1'b1}}};
            1:       return {1'b1, {(SBITS-1){1'b0}}};
            // A narrow range around zero gives many ties inside the window.
            2, 3, 4: return SBITS'($urandom_range(6)) - SBITS'(3);
            default: return SBITS'($urandom);
        endcase
    endfunction

    // Offers one pixel request, with random idle cycles in front of it, and returns
    // at the edge where the block takes it.
    task automatic send_item(input logic act, input logic [SBITS-1:0] smp);
        while ($urandom_range(99) < send_idle[idle_phase]) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= DATA_W'(smp);
        do @(posedge aclk); while (s_tready !== 1'b1);
    endtask

    // Registers may only change while the block is idle, so let the pipeline empty
    // of every request and then wait until each pending result has been taken.
    task automatic settle();
        s_tvalid <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge aclk);
        while (sb.expected.size() != 0) @(posedge aclk);
    endtask

    task automatic write_register(input logic idx, input int unsigned value);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= mf3_pkg::CFG_DATA_BITS'(value);
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
    endtask

    // Writes both registers and hands back the frame size the block will use.
    task automatic configure(input int unsigned w_raw, input int unsigned h_raw,
                             output int unsigned w, output int unsigned h);
        write_register(mf3_pkg::REG_IMAGE_WIDTH, w_raw);
        write_register(mf3_pkg::REG_IMAGE_HEIGHT, h_raw);
        w = median_scoreboard::usable_width(w_raw);
        h = median_scoreboard::usable_height(h_raw);
    endtask

    // Sends the pixels of one frame with random content and a few premature flush
    // ticks mixed in. When all pixels are sent, the frame is drained with a random mix
    // of flush ticks and pushes; a shorter count leaves the frame unfinished.
    task automatic run_frame(input int unsigned w, input int unsigned h,
                             input int unsigned pixels);
        int unsigned k;
        for (k = 0; k < pixels; k++) begin
            if ($urandom_range(99) < 6)
                send_item(mf3_pkg::ACT_FLUSH, SBITS'($urandom));
            send_item(mf3_pkg::ACT_PUSH, pick_sample());
        end
        if (pixels == w * h) begin
            for (k = 0; k <= w; k++)
                send_item($urandom_range(1) ? mf3_pkg::ACT_FLUSH : mf3_pkg::ACT_PUSH,
                          pick_sample());
        end
    endtask

    initial begin
        int unsigned w;
        int unsigned h;
        int unsigned w_raw;
        int unsigned h_raw;
        int          base;
        int          k;
        logic [SBITS-1:0] hi_val;
        logic [SBITS-1:0] lo_val;

        hi_val = {1'b0, {(SBITS-1){1'b1}}};
        lo_val = {1'b1, {(SBITS-1){1'b0}}};
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= mf3_pkg::ACT_PUSH;
        cfg_valid <= 1'b0;
        cfg_index <= mf3_pkg::REG_IMAGE_WIDTH;
        cfg_data  <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // A flush tick right after reset finds no pixels and must be ignored.
        send_item(mf3_pkg::ACT_FLUSH, '1);

        // A 3x3 frame of alternating extremes. Only the center output sees a full
        // window; all the others are bordered by zeros.
        configure(3, 3, w, h);
        for (k = 0; k < 9; k++)
            send_item(mf3_pkg::ACT_PUSH, (k % 2) ? lo_val : hi_val);
        send_item(mf3_pkg::ACT_FLUSH, '0);
        send_item(mf3_pkg::ACT_PUSH, SBITS'(16'h1234));
        send_item(mf3_pkg::ACT_FLUSH, '0);
        send_item(mf3_pkg::ACT_PUSH, '1);
        // The frame has ended, so this flush belongs to a new frame and is dropped.
        send_item(mf3_pkg::ACT_FLUSH, '0);

        // Width one and height zero are both raised to the smallest frame, 2x2.
        configure(1, 0, w, h);
        send_item(mf3_pkg::ACT_PUSH, '0);
        send_item(mf3_pkg::ACT_PUSH, '1);
        send_item(mf3_pkg::ACT_FLUSH, hi_val);
        send_item(mf3_pkg::ACT_PUSH, hi_val);
        send_item(mf3_pkg::ACT_PUSH, lo_val);
        send_item(mf3_pkg::ACT_PUSH, '0);
        send_item(mf3_pkg::ACT_FLUSH, '1);
        send_item(mf3_pkg::ACT_PUSH, lo_val);

        // An all-ones width lands above the limit and is clamped to the widest row, in
        // the tallest frame. One full row and a few pixels reach the highest line store
        // address and the wrap of the column counter. The receiver holds off from the
        // first result on, so the queue fills and the pixel input stalls.
        configure(16'hFFFF, 16'hFFFF, w, h);
        hold_armed = 1'b1;
        run_frame(w, h, w + 12);

        // Random frames, mostly small and complete, some cut short by a new setting.
        base = sb.taken;
        while (sb.taken - base < RANDOM_ITEMS) begin
            idle_phase = ((sb.taken - base) * 3) / RANDOM_ITEMS;
            if (idle_phase > 2) idle_phase = 2;
            case ($urandom_range(9))
                0:       w_raw = $urandom_range(1);
                1:       w_raw = $urandom_range(40, 13);
                default: w_raw = $urandom_range(12, 2);
            endcase
            h_raw = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(6, 2);
            configure(w_raw, h_raw, w, h);
            if ($urandom_range(9) == 0) begin
                run_frame(w, h, $urandom_range(w * h - 1, 1));
            end else begin
                repeat ($urandom_range(3, 1)) run_frame(w, h, w * h);
            end
        end

        s_tvalid <= 1'b0;
        while (sb.expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[median_filter_3x3_zero_pad.f]
hdl/mf3_pkg.sv
hdl/mf3_line_mem.sv
hdl/mf3_median.sv
hdl/mf3_out_fifo.sv
hdl/median_filter_3x3_zero_pad.sv
hdl/mf3_checker.sv
tb/sv/tb_median_filter_3x3_zero_pad.sv
